>>> hdl/usr_pkg.sv
`default_nettype none

package usr_pkg;

   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int COUNT_WIDTH_DEFAULT = 10;

   // Integer bits of the line sample format; the rest are fraction bits.
   localparam int INT_BITS = 4;
   localparam int LEVEL_WIDTH = INT_BITS + 2;
   localparam int THRESHOLD_WIDTH = 15;
   localparam int DATA_BITS = 8;
   localparam int BIT_INDEX_WIDTH = 4;

   localparam int BIT_PERIOD_RESET = 16;
   localparam logic [THRESHOLD_WIDTH-1:0] EDGE_THRESHOLD_RESET = THRESHOLD_WIDTH'(2048);
   localparam logic PARITY_ENABLED_RESET = 1'b0;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIT_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EDGE_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PARITY_ENABLED = 2'd2;

   typedef struct packed {
      logic start_edge;
      logic level_match;
      logic bit_one;
   } sample_flags_type;

endpackage

`default_nettype wire

>>> hdl/usr_sample_eval.sv
`default_nettype none

module usr_sample_eval #(
   parameter int SAMPLE_WIDTH = usr_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic signed [SAMPLE_WIDTH-1:0]          sample,
   input  logic signed [SAMPLE_WIDTH-1:0]          prev_sample,
   input  logic [usr_pkg::THRESHOLD_WIDTH-1:0]     edge_threshold,
   output usr_pkg::sample_flags_type               flags
);

   localparam int FRAC_BITS = SAMPLE_WIDTH - usr_pkg::INT_BITS;
   localparam int LW = usr_pkg::LEVEL_WIDTH;
   localparam int DIFF_WIDTH = (SAMPLE_WIDTH + 1 > usr_pkg::THRESHOLD_WIDTH + 1) ?
                               SAMPLE_WIDTH + 1 : usr_pkg::THRESHOLD_WIDTH + 1;
   localparam logic [SAMPLE_WIDTH:0] HALF = (SAMPLE_WIDTH + 1)'(1) << (FRAC_BITS - 1);

   // Rounds half away from zero to the nearest whole level.
   function automatic logic signed [LW-1:0] level_of(input logic signed [SAMPLE_WIDTH-1:0] x);
      logic [SAMPLE_WIDTH-1:0] mag;
      logic [SAMPLE_WIDTH:0]   sum;
      logic [LW-2:0]           q;
      mag = x[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(~x + 1'b1) : SAMPLE_WIDTH'(x);
      sum = {1'b0, mag} + HALF;
      q = sum[SAMPLE_WIDTH:FRAC_BITS];
      level_of = x[SAMPLE_WIDTH-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
   endfunction

   logic signed [LW-1:0]         level_now;
   logic signed [LW-1:0]         level_prev;
   logic signed [DIFF_WIDTH-1:0] fall;
   logic signed [DIFF_WIDTH-1:0] threshold_ext;

   assign level_now = level_of(sample);
   assign level_prev = level_of(prev_sample);
   assign fall = DIFF_WIDTH'(prev_sample) - DIFF_WIDTH'(sample);
   assign threshold_ext = $signed(DIFF_WIDTH'(edge_threshold));

   assign flags.start_edge = (level_now == '0) && (fall > threshold_ext);
   assign flags.level_match = (level_now == level_prev);
   assign flags.bit_one = $signed({sample[SAMPLE_WIDTH-1], sample}) >= $signed(HALF);

endmodule

`default_nettype wire

>>> hdl/usr_frame_fsm.sv
`default_nettype none

module usr_frame_fsm #(
   parameter int COUNT_WIDTH = usr_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  usr_pkg::sample_flags_type  flags,
   input  logic [COUNT_WIDTH-1:0]     bit_period,
   input  logic                       parity_enabled,
   output logic                       emit,
   output logic [usr_pkg::DATA_BITS-1:0] data_byte
);

   typedef enum logic [5:0] {
      PH_HUNT      = 6'b000001,
      PH_COUNT     = 6'b000010,
      PH_DATA      = 6'b000100,
      PH_PARITY    = 6'b001000,
      PH_STOP      = 6'b010000,
      PH_STOP_TAIL = 6'b100000
   } phase_type;

   localparam int BW = usr_pkg::BIT_INDEX_WIDTH;
   localparam int DB = usr_pkg::DATA_BITS;

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [BW-1:0]          bit_ff, bit_in;
   logic [DB-1:0]          shift_ff, shift_in;

   logic [COUNT_WIDTH-1:0] bit_len;
   logic [COUNT_WIDTH-1:0] mid;
   logic [COUNT_WIDTH:0]   count_plus;
   logic [COUNT_WIDTH:0]   match_count;
   logic                   count_last;
   logic [BW-1:0]          bit_plus;

   assign bit_len = (bit_period == '0) ? COUNT_WIDTH'(1) : bit_period;
   assign mid = bit_len >> 1;
   assign count_plus = {1'b0, count_ff} + (COUNT_WIDTH + 1)'(1);
   assign count_last = count_plus >= {1'b0, bit_len};
   assign match_count = flags.level_match ? count_plus : {1'b0, count_ff};
   assign bit_plus = bit_ff + BW'(1);
   assign data_byte = shift_ff;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      bit_in = bit_ff;
      shift_in = shift_ff;
      emit = 1'b0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (flags.start_edge) begin
               phase_in = PH_COUNT;
               count_in = '0;
            end
         end
         PH_COUNT: begin
            if (match_count >= {1'b0, bit_len}) begin
               phase_in = PH_DATA;
               count_in = '0;
               bit_in = '0;
               shift_in = '0;
            end else begin
               count_in = match_count[COUNT_WIDTH-1:0];
            end
         end
         PH_DATA: begin
            if (count_ff == mid) begin
               shift_in = {flags.bit_one, shift_ff[DB-1:1]};
            end
            if (count_last) begin
               count_in = '0;
               bit_in = bit_plus;
               if (bit_plus >= BW'(DB)) begin
                  phase_in = parity_enabled ? PH_PARITY : PH_STOP;
               end
            end else begin
               count_in = count_plus[COUNT_WIDTH-1:0];
            end
         end
         PH_PARITY: begin
            if (count_last) begin
               count_in = '0;
               phase_in = PH_STOP;
            end else begin
               count_in = count_plus[COUNT_WIDTH-1:0];
            end
         end
         PH_STOP: begin
            if (count_ff >= mid) begin
               if (flags.bit_one) begin
                  emit = 1'b1;
                  if (count_last) begin
                     phase_in = PH_HUNT;
                     count_in = '0;
                  end else begin
                     phase_in = PH_STOP_TAIL;
                     count_in = count_plus[COUNT_WIDTH-1:0];
                  end
               end else begin
                  phase_in = PH_HUNT;
                  count_in = '0;
               end
            end else begin
               count_in = count_plus[COUNT_WIDTH-1:0];
            end
         end
         PH_STOP_TAIL: begin
            if (count_last) begin
               phase_in = PH_HUNT;
               count_in = '0;
            end else begin
               count_in = count_plus[COUNT_WIDTH-1:0];
            end
         end
         default: begin
            phase_in = PH_HUNT;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         bit_ff <= '0;
         shift_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         bit_ff <= bit_in;
         shift_ff <= shift_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/uart_sample_receiver_core.sv
// UART receiver for 8 data bits, an optional parity bit and one stop bit, fed with
// samples of an idle-high serial line in signed fixed point (4 integer bits).
// Each item on the req_ channel is one line sample; an item on the rsp_ channel is
// one received byte, sent only when the stop bit reads high.
// The csr_ port writes samples per bit, the start edge threshold and the parity
// enable; write it only while no item is in flight.
// An accepted item is held in the input register, and its byte, if it makes one, is
// registered into the output register that drives rsp_valid as the item moves on.
// One item is taken per cycle outside stalls; the frame state updates once per item.
// When the rsp_ side stalls, items that produce no byte still pass, and the input
// register holds an item that would produce a byte until the output register drains.
// Reset clears the frame state, the previous sample and both valid flags, and loads
// the register defaults: 16 samples per bit, threshold 2048 and parity off.
`default_nettype none

module uart_sample_receiver_core #(
   parameter int SAMPLE_WIDTH = usr_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = usr_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]           req_line_sample,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [usr_pkg::DATA_BITS-1:0]            rsp_data_byte,
   input  logic                                     csr_we,
   input  logic [usr_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [((COUNT_WIDTH > usr_pkg::THRESHOLD_WIDTH) ?
                  COUNT_WIDTH : usr_pkg::THRESHOLD_WIDTH)-1:0] csr_wdata
);

   localparam int TW = usr_pkg::THRESHOLD_WIDTH;

   logic [COUNT_WIDTH-1:0]         spb_ff;
   logic [TW-1:0]                  threshold_ff;
   logic                           parity_ff;

   logic                           s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_WIDTH-1:0] prev_ff, prev_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [usr_pkg::DATA_BITS-1:0]  rsp_byte_ff, rsp_byte_in;

   usr_pkg::sample_flags_type      flags;
   logic                           emit;
   logic [usr_pkg::DATA_BITS-1:0]  frame_byte;
   logic                           out_free;
   logic                           advance;
   logic                           req_take;

   usr_sample_eval #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_eval (
      .sample(sample_ff),
      .prev_sample(prev_ff),
      .edge_threshold(threshold_ff),
      .flags(flags)
   );

   usr_frame_fsm #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_fsm (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .flags(flags),
      .bit_period(spb_ff),
      .parity_enabled(parity_ff),
      .emit(emit),
      .data_byte(frame_byte)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance = s1_valid_ff && (!emit || out_free);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data_byte = rsp_byte_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      sample_in = req_take ? req_line_sample : sample_ff;
      prev_in = advance ? sample_ff : prev_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in = rsp_byte_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in = frame_byte;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         prev_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         prev_ff <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spb_ff <= COUNT_WIDTH'(usr_pkg::BIT_PERIOD_RESET);
         threshold_ff <= usr_pkg::EDGE_THRESHOLD_RESET;
         parity_ff <= usr_pkg::PARITY_ENABLED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            usr_pkg::CSR_BIT_PERIOD:      spb_ff <= csr_wdata[COUNT_WIDTH-1:0];
            usr_pkg::CSR_EDGE_THRESHOLD:  threshold_ff <= csr_wdata[TW-1:0];
            usr_pkg::CSR_PARITY_ENABLED:  parity_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // A new byte never lands on a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !(advance && emit))
      else $error("result register overwritten while stalled");

   // A held item moves on whenever the output side has room.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_free) |-> advance)
      else $error("input register stalled with a free output");

   // The previous sample follows every processed item.
   a_prev_tracks: assert property (@(posedge clock) disable iff (reset)
      advance |=> (prev_ff == $past(sample_ff)))
      else $error("previous sample not updated");

endmodule

`default_nettype wire
